// File: rtl/n6502as_pkg.sv
// Shared types and constants for the 6502 ALU and status unit.
package n6502as_pkg;

   // Operation codes of a request
   typedef enum logic [4:0] {
      ACT_ADC     = 5'd0,
      ACT_SBC     = 5'd1,
      ACT_AND     = 5'd2,
      ACT_ORA     = 5'd3,
      ACT_EOR     = 5'd4,
      ACT_BIT     = 5'd5,
      ACT_CMP     = 5'd6,
      ACT_INC     = 5'd7,
      ACT_DEC     = 5'd8,
      ACT_ROL     = 5'd9,
      ACT_ROR     = 5'd10,
      ACT_ASL     = 5'd11,
      ACT_LSR     = 5'd12,
      ACT_LOAD    = 5'd13,
      ACT_PASS    = 5'd14,
      ACT_SETFLAG = 5'd15,
      ACT_BRANCH  = 5'd16,
      ACT_RESTORE = 5'd17,
      ACT_PUSH    = 5'd18,
      ACT_BREAK   = 5'd19
   } action_type;

   // Flag tested by a branch
   localparam logic [1:0] BR_N = 2'd0;
   localparam logic [1:0] BR_V = 2'd1;
   localparam logic [1:0] BR_C = 2'd2;
   localparam logic [1:0] BR_Z = 2'd3;

   // Flag written by a flag set or clear
   localparam logic [1:0] SEL_C = 2'd0;
   localparam logic [1:0] SEL_I = 2'd1;
   localparam logic [1:0] SEL_V = 2'd2;
   localparam logic [1:0] SEL_D = 2'd3;

   // Bit positions in the status byte, NV-BDIZC
   localparam int unsigned FLAG_C = 0;
   localparam int unsigned FLAG_Z = 1;
   localparam int unsigned FLAG_I = 2;
   localparam int unsigned FLAG_D = 3;
   localparam int unsigned FLAG_B = 4;
   localparam int unsigned FLAG_U = 5;
   localparam int unsigned FLAG_V = 6;
   localparam int unsigned FLAG_N = 7;

   localparam logic [7:0] STATUS_RESET = 8'h24;
   localparam logic [7:0] PUSH_BITS    = 8'h30;

   // One request as held in the input register
   typedef struct packed {
      action_type action;
      logic [7:0] left_value;
      logic [7:0] operand;
      logic [1:0] branch_flag;
      logic [1:0] flag_select;
      logic       flag_value;
   } req_type;

   // One response as held in the result register
   typedef struct packed {
      logic [7:0] result;
      logic [7:0] status_out;
      logic       branch_taken;
   } rsp_type;

endpackage

// File: rtl/nmos_6502_alu_status.sv
// Top level of the 6502 ALU and processor status unit.
//
// Usage:
//   Request channel (req_*): one 6502 operation with its left byte, operand
//   byte, branch flag code, flag select code and flag value. Accepted at a
//   rising edge with req_valid high and req_stall low.
//   Response channel (rsp_*): result byte, status after the operation and
//   the branch-taken bit, one response per request, in request order.
// Path: a request is held in the input register, then in the result register.
// Throughput: one request per cycle while rsp_stall is low. The status byte
//   is written when a request moves from the input register to the result
//   register, so the request behind it sees the updated flags in the very next cycle.
// Reset: synchronous, active high. Both registers are emptied and the
//   status byte returns to 0x24 (I and the unused bit set).
// Stall: while rsp_stall holds a response, the input register still takes
//   one more request; req_stall rises only when both registers are full.
module nmos_6502_alu_status (
   input  logic       clock,
   input  logic       reset,
   // request channel
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [4:0] req_action,
   input  logic [7:0] req_left_value,
   input  logic [7:0] req_operand,
   input  logic [1:0] req_branch_flag,
   input  logic [1:0] req_flag_select,
   input  logic       req_flag_value,
   // response channel
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_result,
   output logic [7:0] rsp_status_out,
   output logic       rsp_branch_taken
);

   logic                 in_valid_ff;
   logic                 in_valid_in;
   n6502as_pkg::req_type in_req_ff;
   n6502as_pkg::req_type in_req_in;
   logic                 out_valid_ff;
   logic                 out_valid_in;
   n6502as_pkg::rsp_type out_rsp_ff;
   logic [7:0]           status_ff;
   logic [7:0]           status_in;
   n6502as_pkg::rsp_type alu_rsp;
   logic                 advance;
   logic                 move;
   logic                 req_take;

   // advance the result register when it is empty or being drained
   assign advance  = ~out_valid_ff | ~rsp_stall;
   assign move     = in_valid_ff & advance;
   assign req_stall = in_valid_ff & ~advance;
   assign req_take = req_valid & ~req_stall;

   // pack the request
   always_comb begin
      in_req_in.action      = n6502as_pkg::action_type'(req_action);
      in_req_in.left_value  = req_left_value;
      in_req_in.operand     = req_operand;
      in_req_in.branch_flag = req_branch_flag;
      in_req_in.flag_select = req_flag_select;
      in_req_in.flag_value  = req_flag_value;
   end

   n6502as_alu u_alu (
      .req_in    (in_req_ff),
      .status_in (status_ff),
      .rsp_out   (alu_rsp)
   );

   // next values of valid bits and status
   assign in_valid_in  = req_take | (in_valid_ff & ~move);
   assign out_valid_in = move | (out_valid_ff & rsp_stall);
   assign status_in    = move ? alu_rsp.status_out : status_ff;

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         status_ff    <= n6502as_pkg::STATUS_RESET;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         status_ff    <= status_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_take) begin
         in_req_ff <= in_req_in;
      end
      if (move) begin
         out_rsp_ff <= alu_rsp;
      end
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_result       = out_rsp_ff.result;
   assign rsp_status_out   = out_rsp_ff.status_out;
   assign rsp_branch_taken = out_rsp_ff.branch_taken;

   // the unused status bit stays set
   a_unused_bit: assert property (@(posedge clock) disable iff (reset)
      status_ff[n6502as_pkg::FLAG_U])
      else $error("status unused bit cleared");

   // status changes only when a request moves to the result register
   a_status_hold: assert property (@(posedge clock) disable iff (reset)
      !move |=> $stable(status_ff))
      else $error("status changed without a request");

   // a loaded response carries the status that was committed with it
   a_status_match: assert property (@(posedge clock) disable iff (reset)
      move |=> (rsp_valid && rsp_status_out == status_ff))
      else $error("response status differs from held status");

   // requests are held back only when both registers are full
   a_stall_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (in_valid_ff && out_valid_ff && rsp_stall))
      else $error("request stalled with room available");

endmodule

// File: rtl/n6502as_alu.sv
// Combinational ALU step: result byte, next status and branch decision.
module n6502as_alu (
   input  n6502as_pkg::req_type req_in,
   input  logic [7:0]           status_in,
   output n6502as_pkg::rsp_type rsp_out
);

   logic [7:0] a;
   logic [7:0] b;
   logic       cin;
   logic       bin;

   // binary add and subtract
   logic [8:0] add_sum;
   logic [8:0] sub_diff;
   logic [8:0] cmp_diff;

   // decimal add
   logic [5:0] dadd_lo_raw;
   logic [5:0] dadd_lo;
   logic [8:0] dadd_hi_raw;
   logic [9:0] dadd_hi;

   // decimal subtract, two's complement in 6 and 10 bits
   logic [5:0] dsub_lo_raw;
   logic [5:0] dsub_lo;
   logic [9:0] dsub_hi_raw;
   logic [9:0] dsub_hi;

   logic [7:0] res;
   logic [7:0] st;
   logic       taken;

   assign a   = req_in.left_value;
   assign b   = req_in.operand;
   assign cin = status_in[n6502as_pkg::FLAG_C];
   assign bin = ~cin;

   assign add_sum  = {1'b0, a} + {1'b0, b} + {8'd0, cin};
   assign sub_diff = {1'b0, a} - {1'b0, b} - {8'd0, bin};
   assign cmp_diff = {1'b0, a} - {1'b0, b};

   // decimal add: low nibble corrected before the high nibble sum
   assign dadd_lo_raw = {2'b00, a[3:0]} + {2'b00, b[3:0]} + {5'd0, cin};
   assign dadd_lo     = (dadd_lo_raw > 6'd9) ? dadd_lo_raw + 6'd6 : dadd_lo_raw;
   assign dadd_hi_raw = {1'b0, a[7:4], 4'd0} + {1'b0, b[7:4], 4'd0}
                        + ((dadd_lo > 6'd15) ? 9'h010 : 9'h000);
   assign dadd_hi     = (dadd_hi_raw > 9'h090) ? {1'b0, dadd_hi_raw} + 10'h060
                                               : {1'b0, dadd_hi_raw};

   // decimal subtract: fold a negative low nibble, then bias a negative high part
   assign dsub_lo_raw = {2'b00, a[3:0]} - {2'b00, b[3:0]} - {5'd0, bin};
   assign dsub_lo     = dsub_lo_raw[5] ? {2'b11, dsub_lo_raw[3:0] + 4'd10} : dsub_lo_raw;
   assign dsub_hi_raw = {2'b00, a[7:4], 4'd0} - {2'b00, b[7:4], 4'd0}
                        + {{4{dsub_lo[5]}}, dsub_lo};
   assign dsub_hi     = dsub_hi_raw[9] ? dsub_hi_raw - 10'h060 : dsub_hi_raw;

   // decode the operation
   always_comb begin
      res   = a;
      st    = status_in;
      taken = 1'b0;
      unique case (req_in.action) inside
         n6502as_pkg::ACT_ADC: begin
            if (status_in[n6502as_pkg::FLAG_D]) begin
               res                      = {dadd_hi[7:4], dadd_lo[3:0]};
               st[n6502as_pkg::FLAG_Z]  = (add_sum[7:0] == 8'd0);
               st[n6502as_pkg::FLAG_N]  = dadd_hi_raw[7];
               st[n6502as_pkg::FLAG_V]  = ~(a[7] ^ b[7]) & (a[7] ^ dadd_hi_raw[7]);
               st[n6502as_pkg::FLAG_C]  = (dadd_hi > 10'h0FF);
            end else begin
               res                      = add_sum[7:0];
               st[n6502as_pkg::FLAG_Z]  = (add_sum[7:0] == 8'd0);
               st[n6502as_pkg::FLAG_N]  = add_sum[7];
               st[n6502as_pkg::FLAG_V]  = ~(a[7] ^ b[7]) & (a[7] ^ add_sum[7]);
               st[n6502as_pkg::FLAG_C]  = add_sum[8];
            end
         end
         n6502as_pkg::ACT_SBC: begin
            res                     = status_in[n6502as_pkg::FLAG_D] ? dsub_hi[7:0]
                                                                     : sub_diff[7:0];
            st[n6502as_pkg::FLAG_Z] = (sub_diff[7:0] == 8'd0);
            st[n6502as_pkg::FLAG_N] = sub_diff[7];
            st[n6502as_pkg::FLAG_V] = (a[7] ^ sub_diff[7]) & (a[7] ^ b[7]);
            st[n6502as_pkg::FLAG_C] = ~sub_diff[8];
         end
         n6502as_pkg::ACT_AND: begin
            res                     = a & b;
            st[n6502as_pkg::FLAG_Z] = (res == 8'd0);
            st[n6502as_pkg::FLAG_N] = res[7];
         end
         n6502as_pkg::ACT_ORA: begin
            res                     = a | b;
            st[n6502as_pkg::FLAG_Z] = (res == 8'd0);
            st[n6502as_pkg::FLAG_N] = res[7];
         end
         n6502as_pkg::ACT_EOR: begin
            res                     = a ^ b;
            st[n6502as_pkg::FLAG_Z] = (res == 8'd0);
            st[n6502as_pkg::FLAG_N] = res[7];
         end
         n6502as_pkg::ACT_BIT: begin
            st[n6502as_pkg::FLAG_Z] = ((a & b) == 8'd0);
            st[n6502as_pkg::FLAG_V] = b[6];
            st[n6502as_pkg::FLAG_N] = b[7];
         end
         n6502as_pkg::ACT_CMP: begin
            st[n6502as_pkg::FLAG_C] = ~cmp_diff[8];
            st[n6502as_pkg::FLAG_Z] = (cmp_diff[7:0] == 8'd0);
            st[n6502as_pkg::FLAG_N] = cmp_diff[7];
         end
         n6502as_pkg::ACT_INC: begin
            res                     = a + 8'd1;
            st[n6502as_pkg::FLAG_Z] = (res == 8'd0);
            st[n6502as_pkg::FLAG_N] = res[7];
         end
         n6502as_pkg::ACT_DEC: begin
            res                     = a - 8'd1;
            st[n6502as_pkg::FLAG_Z] = (res == 8'd0);
            st[n6502as_pkg::FLAG_N] = res[7];
         end
         n6502as_pkg::ACT_ROL, n6502as_pkg::ACT_ASL: begin
            res = {a[6:0], (req_in.action == n6502as_pkg::ACT_ROL) & cin};
            st[n6502as_pkg::FLAG_C] = a[7];
            st[n6502as_pkg::FLAG_Z] = (res == 8'd0);
            st[n6502as_pkg::FLAG_N] = res[7];
         end
         n6502as_pkg::ACT_ROR, n6502as_pkg::ACT_LSR: begin
            res = {(req_in.action == n6502as_pkg::ACT_ROR) & cin, a[7:1]};
            st[n6502as_pkg::FLAG_C] = a[0];
            st[n6502as_pkg::FLAG_Z] = (res == 8'd0);
            st[n6502as_pkg::FLAG_N] = res[7];
         end
         n6502as_pkg::ACT_LOAD: begin
            res                     = b;
            st[n6502as_pkg::FLAG_Z] = (b == 8'd0);
            st[n6502as_pkg::FLAG_N] = b[7];
         end
         n6502as_pkg::ACT_PASS: begin
            st[n6502as_pkg::FLAG_Z] = (a == 8'd0);
            st[n6502as_pkg::FLAG_N] = a[7];
         end
         n6502as_pkg::ACT_SETFLAG: begin
            unique case (req_in.flag_select)
               n6502as_pkg::SEL_C: st[n6502as_pkg::FLAG_C] = req_in.flag_value;
               n6502as_pkg::SEL_I: st[n6502as_pkg::FLAG_I] = req_in.flag_value;
               n6502as_pkg::SEL_V: st[n6502as_pkg::FLAG_V] = req_in.flag_value;
               n6502as_pkg::SEL_D: st[n6502as_pkg::FLAG_D] = req_in.flag_value;
               default:            st = status_in;
            endcase
         end
         n6502as_pkg::ACT_BRANCH: begin
            unique case (req_in.branch_flag)
               n6502as_pkg::BR_N: taken = (status_in[n6502as_pkg::FLAG_N] == req_in.flag_value);
               n6502as_pkg::BR_V: taken = (status_in[n6502as_pkg::FLAG_V] == req_in.flag_value);
               n6502as_pkg::BR_C: taken = (status_in[n6502as_pkg::FLAG_C] == req_in.flag_value);
               n6502as_pkg::BR_Z: taken = (status_in[n6502as_pkg::FLAG_Z] == req_in.flag_value);
               default:           taken = 1'b0;
            endcase
         end
         n6502as_pkg::ACT_RESTORE: begin
            // keep B and the unused bit, take the rest from the pulled byte
            st = {b[7:6], status_in[5:4], b[3:0]};
         end
         n6502as_pkg::ACT_PUSH: begin
            res = status_in | n6502as_pkg::PUSH_BITS;
         end
         n6502as_pkg::ACT_BREAK: begin
            res                     = status_in | n6502as_pkg::PUSH_BITS;
            st[n6502as_pkg::FLAG_B] = 1'b1;
            st[n6502as_pkg::FLAG_I] = 1'b1;
         end
         default: begin
            res = a;
         end
      endcase
   end

   assign rsp_out.result       = res;
   assign rsp_out.status_out   = st;
   assign rsp_out.branch_taken = taken;

endmodule
